[hdl/tbc_pkg.sv]
// Shared types and constants for the triangle backface cull block.
// No dependencies; imported by the datapath top level.
package tbc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  // poly_status bit positions
  localparam int STAT_ACTIVE    = 0;
  localparam int STAT_CLIPPED   = 1;
  localparam int STAT_TWO_SIDED = 2;
  localparam int STAT_BACKFACE  = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_CAMERA_X = 2'd0,
    REG_CAMERA_Y = 2'd1,
    REG_CAMERA_Z = 2'd2
  } cfg_reg_t;

  // sideband that rides along with each item through the pipe
  typedef struct packed {
    logic skip;
    logic back_in;
    logic last;
  } ctl_t;

endpackage

[hdl/triangle_backface_cull.sv]
// Backface cull pipeline: cross product of two triangle edges, dot with view vector.
// Depends on tbc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one triangle per item: three
//   vertices, poly_status, object_culled and last_triangle. Output channel
//   (out_valid/out_ready) gives one result per item, in order:
//   backface_out, tested and last_out.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   camera position; it is always ready, unknown indexes are dropped.
//   Write it only while no item is in flight.
// Timing:
//   Six register stages: edge differences, cross products, normal,
//   dot partial products, partial sums, final add and sign test into the
//   output register. One item per cycle sustained while out_ready stays high.
// Reset: clears all stage valid bits and the camera registers to zero.
// Stall: each stage moves on when it is empty or the stage after it moves,
//   so bubbles collapse; with out_ready low the pipe fills and in_ready
//   drops only once all six stages hold an item.
module triangle_backface_cull
  import tbc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic signed [COORD_WIDTH-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] p0_x,
  input  logic signed [COORD_WIDTH-1:0] p0_y,
  input  logic signed [COORD_WIDTH-1:0] p0_z,
  input  logic signed [COORD_WIDTH-1:0] p1_x,
  input  logic signed [COORD_WIDTH-1:0] p1_y,
  input  logic signed [COORD_WIDTH-1:0] p1_z,
  input  logic signed [COORD_WIDTH-1:0] p2_x,
  input  logic signed [COORD_WIDTH-1:0] p2_y,
  input  logic signed [COORD_WIDTH-1:0] p2_z,
  input  logic [3:0]                    poly_status,
  input  logic                          object_culled,
  input  logic                          last_triangle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          backface_out,
  output logic                          tested,
  output logic                          last_out
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;       // edge / view vector
  localparam int CPW = 2 * W + 2;   // cross product terms
  localparam int NW  = 2 * W + 3;   // normal components
  localparam int K   = W + 1;       // low split of normal
  localparam int HW  = NW - K;      // high part of normal, signed
  localparam int PW  = 2 * W + 3;   // dot partial products
  localparam int SW  = PW + 2;      // sum of three partials
  localparam int DPW = SW + K;      // full dot product

  // ---------------- configuration ----------------
  logic signed [W-1:0] camera_x;
  logic signed [W-1:0] camera_y;
  logic signed [W-1:0] camera_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
      camera_z <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAMERA_X: camera_x <= cfg_data;
        REG_CAMERA_Y: camera_y <= cfg_data;
        REG_CAMERA_Z: camera_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic [6:1] vld;
  logic [7:1] adv;
  ctl_t       ctl [5:1];
  ctl_t       ctl_in;

  always_comb begin
    adv[7] = out_ready;
    for (int s = 6; s >= 1; s--) begin
      adv[s] = !vld[s] || adv[s+1];
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= in_valid;
      end
      for (int s = 2; s <= 6; s++) begin
        if (adv[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  assign ctl_in.skip    = object_culled || !poly_status[STAT_ACTIVE] ||
                          poly_status[STAT_CLIPPED] || poly_status[STAT_TWO_SIDED] ||
                          poly_status[STAT_BACKFACE];
  assign ctl_in.back_in = poly_status[STAT_BACKFACE];
  assign ctl_in.last    = last_triangle;

  // stage 6 takes its sideband straight into the output registers
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ctl[1] <= ctl_in;
    end
    for (int s = 2; s <= 5; s++) begin
      if (adv[s]) begin
        ctl[s] <= ctl[s-1];
      end
    end
  end

  // ---------------- stage 1: edges and view vector ----------------
  logic signed [W-1:0]  a0 [3];
  logic signed [W-1:0]  a1 [3];
  logic signed [W-1:0]  a2 [3];
  logic signed [W-1:0]  cam [3];
  logic signed [DW-1:0] du [3];
  logic signed [DW-1:0] dv [3];
  logic signed [DW-1:0] w1 [3];

  assign a0  = '{p0_x, p0_y, p0_z};
  assign a1  = '{p1_x, p1_y, p1_z};
  assign a2  = '{p2_x, p2_y, p2_z};
  assign cam = '{camera_x, camera_y, camera_z};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        du[i] <= $signed({a1[i][W-1], a1[i]}) - $signed({a0[i][W-1], a0[i]});
        dv[i] <= $signed({a2[i][W-1], a2[i]}) - $signed({a0[i][W-1], a0[i]});
        w1[i] <= $signed({cam[i][W-1], cam[i]}) - $signed({a0[i][W-1], a0[i]});
      end
    end
  end

  // ---------------- stage 2: cross product terms ----------------
  // cp[2i] - cp[2i+1] is component i of u x v
  logic signed [CPW-1:0] cpa [6];
  logic signed [CPW-1:0] cpb [6];
  logic signed [CPW-1:0] cp  [6];
  logic signed [DW-1:0]  w2  [3];

  function automatic logic signed [CPW-1:0] ext_cp(input logic signed [DW-1:0] x);
    ext_cp = {{(CPW-DW){x[DW-1]}}, x};
  endfunction

  always_comb begin
    cpa[0] = ext_cp(du[1]); cpb[0] = ext_cp(dv[2]);
    cpa[1] = ext_cp(du[2]); cpb[1] = ext_cp(dv[1]);
    cpa[2] = ext_cp(du[2]); cpb[2] = ext_cp(dv[0]);
    cpa[3] = ext_cp(du[0]); cpb[3] = ext_cp(dv[2]);
    cpa[4] = ext_cp(du[0]); cpb[4] = ext_cp(dv[1]);
    cpa[5] = ext_cp(du[1]); cpb[5] = ext_cp(dv[0]);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 6; i++) begin
        cp[i] <= cpa[i] * cpb[i];
      end
      w2 <= w1;
    end
  end

  // ---------------- stage 3: normal ----------------
  logic signed [NW-1:0] nrm [3];
  logic signed [DW-1:0] w3  [3];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        nrm[i] <= $signed({cp[2*i][CPW-1], cp[2*i]}) -
                  $signed({cp[2*i+1][CPW-1], cp[2*i+1]});
      end
      w3 <= w2;
    end
  end

  // ---------------- stage 4: dot partial products ----------------
  // normal split into unsigned low K bits and signed high part
  logic signed [PW-1:0] lo_op [3];
  logic signed [PW-1:0] hi_op [3];
  logic signed [PW-1:0] w_op  [3];
  logic signed [PW-1:0] pl    [3];
  logic signed [PW-1:0] ph    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_op[i] = {{(PW-K){1'b0}}, nrm[i][K-1:0]};
      hi_op[i] = {{(PW-HW){nrm[i][NW-1]}}, nrm[i][NW-1:K]};
      w_op[i]  = {{(PW-DW){w3[i][DW-1]}}, w3[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) begin
        pl[i] <= lo_op[i] * w_op[i];
        ph[i] <= hi_op[i] * w_op[i];
      end
    end
  end

  // ---------------- stage 5: partial sums ----------------
  logic signed [SW-1:0] sl;
  logic signed [SW-1:0] sh;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      sl <= $signed({{2{pl[0][PW-1]}}, pl[0]}) + $signed({{2{pl[1][PW-1]}}, pl[1]}) +
            $signed({{2{pl[2][PW-1]}}, pl[2]});
      sh <= $signed({{2{ph[0][PW-1]}}, ph[0]}) + $signed({{2{ph[1][PW-1]}}, ph[1]}) +
            $signed({{2{ph[2][PW-1]}}, ph[2]});
    end
  end

  // ---------------- stage 6: combine and test ----------------
  logic [DPW-1:0] dot;
  logic           facing_away;

  assign dot         = {sh, {K{1'b0}}} + {{(DPW-SW){sl[SW-1]}}, sl};
  assign facing_away = dot[DPW-1] || (dot == '0);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      backface_out <= ctl[5].skip ? ctl[5].back_in : facing_away;
      tested       <= !ctl[5].skip;
      last_out     <= ctl[5].last;
    end
  end

endmodule

[hdl/tbc_checker.sv]
// Port-level checks for the backface cull block, attached by bind.
// No package dependencies.
module tbc_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic backface_out,
  input logic tested,
  input logic last_out
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // a waiting result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(backface_out) && $stable(tested) && $stable(last_out))
    else $error("result changed while stalled");

  // output slot free or draining means the whole pipe can advance
  a_ready_when_draining: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled though output can move");

endmodule

bind triangle_backface_cull tbc_checker u_tbc_checker (.*);

[tb/sv/triangle_backface_cull_checker.sv]
// Scoreboard for triangle_backface_cull: tracks camera writes, predicts the
// cull result of every accepted triangle and compares the output items in order.
// Depends on tbc_pkg.
module triangle_backface_cull_checker
  import tbc_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
  input  logic signed [COORD_WIDTH_DEF-1:0] cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [COORD_WIDTH_DEF-1:0] p0_x,
  input  logic signed [COORD_WIDTH_DEF-1:0] p0_y,
  input  logic signed [COORD_WIDTH_DEF-1:0] p0_z,
  input  logic signed [COORD_WIDTH_DEF-1:0] p1_x,
  input  logic signed [COORD_WIDTH_DEF-1:0] p1_y,
  input  logic signed [COORD_WIDTH_DEF-1:0] p1_z,
  input  logic signed [COORD_WIDTH_DEF-1:0] p2_x,
  input  logic signed [COORD_WIDTH_DEF-1:0] p2_y,
  input  logic signed [COORD_WIDTH_DEF-1:0] p2_z,
  input  logic [3:0]                        poly_status,
  input  logic                              object_culled,
  input  logic                              last_triangle,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              backface_out,
  input  logic                              tested,
  input  logic                              last_out,
  output int                                fail_count,
  output int                                outstanding
);

  localparam int REPORT_LINES = 100;

  typedef logic signed [COORD_WIDTH_DEF-1:0] coord_t;
  // wide enough that no difference, product or sum can overflow
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic backface;
    logic tested;
    logic last;
  } verdict_t;

  coord_t   cam_x, cam_y, cam_z;
  verdict_t cull_verdicts[$];
  verdict_t want;

  function automatic verdict_t face_test(
    input coord_t x0, input coord_t y0, input coord_t z0,
    input coord_t x1, input coord_t y1, input coord_t z1,
    input coord_t x2, input coord_t y2, input coord_t z2,
    input logic [3:0] status, input logic culled, input logic last
  );
    wide_t ux, uy, uz, vx, vy, vz, nx, ny, nz, wx, wy, wz, dot;
    verdict_t r;
    r.backface = status[STAT_BACKFACE];
    r.tested   = 1'b0;
    r.last     = last;
    if (!(culled || !status[STAT_ACTIVE] || status[STAT_CLIPPED] ||
          status[STAT_TWO_SIDED] || status[STAT_BACKFACE])) begin
      ux = wide_t'(x1) - wide_t'(x0);
      uy = wide_t'(y1) - wide_t'(y0);
      uz = wide_t'(z1) - wide_t'(z0);
      vx = wide_t'(x2) - wide_t'(x0);
      vy = wide_t'(y2) - wide_t'(y0);
      vz = wide_t'(z2) - wide_t'(z0);
      nx = uy * vz - uz * vy;
      ny = uz * vx - ux * vz;
      nz = ux * vy - uy * vx;
      wx = wide_t'(cam_x) - wide_t'(x0);
      wy = wide_t'(cam_y) - wide_t'(y0);
      wz = wide_t'(cam_z) - wide_t'(z0);
      dot = nx * wx + ny * wy + nz * wz;
      // zero counts as facing away: degenerate or edge-on
      r.backface = (dot <= 0);
      r.tested   = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < REPORT_LINES)
      $display("[%0t] cull check: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      cam_x = '0;
      cam_y = '0;
      cam_z = '0;
      cull_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CAMERA_X: cam_x = cfg_data;
          REG_CAMERA_Y: cam_y = cfg_data;
          REG_CAMERA_Z: cam_z = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        cull_verdicts.push_back(face_test(p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                                          p2_x, p2_y, p2_z, poly_status,
                                          object_culled, last_triangle));
      if (out_valid && out_ready) begin
        if (cull_verdicts.size() == 0) begin
          report_mismatch("result item with no triangle pending");
        end else begin
          want = cull_verdicts.pop_front();
          if (backface_out !== want.backface)
            report_mismatch($sformatf("backface_out %b, want %b", backface_out,
                                      want.backface));
          if (tested !== want.tested)
            report_mismatch($sformatf("tested %b, want %b", tested, want.tested));
          if (last_out !== want.last)
            report_mismatch($sformatf("last_out %b, want %b", last_out, want.last));
        end
      end
    end
    outstanding = cull_verdicts.size();
  end

endmodule

[tb/sv/triangle_backface_cull_tb.sv]
// Top of the triangle_backface_cull bench: clock, reset, camera writes,
// triangle stimulus and output back-pressure; the checker does the scoring.
// Depends on tbc_pkg, triangle_backface_cull and triangle_backface_cull_checker.
module triangle_backface_cull_tb;
  import tbc_pkg::*;

  localparam int PIPE_LATENCY = 6;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_ITEMS  = 156;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  localparam logic [3:0] ST_INACTIVE = 4'b0000;
  localparam logic [3:0] ST_ACTIVE   = 4'(1 << STAT_ACTIVE);
  localparam logic [3:0] ST_CLIPPED  = ST_ACTIVE | 4'(1 << STAT_CLIPPED);
  localparam logic [3:0] ST_TWO_SIDE = ST_ACTIVE | 4'(1 << STAT_TWO_SIDED);
  localparam logic [3:0] ST_BACK     = ST_ACTIVE | 4'(1 << STAT_BACKFACE);
  localparam logic [3:0] ST_BACK_ONLY = 4'(1 << STAT_BACKFACE);

  typedef logic signed [COORD_WIDTH_DEF-1:0] coord_t;

  typedef struct packed {
    coord_t     x0, y0, z0, x1, y1, z1, x2, y2, z2;
    logic [3:0] status;
    logic       culled;
    logic       last;
  } triangle_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  coord_t cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t p0_x = '0, p0_y = '0, p0_z = '0;
  coord_t p1_x = '0, p1_y = '0, p1_z = '0;
  coord_t p2_x = '0, p2_y = '0, p2_z = '0;
  logic [3:0] poly_status = '0;
  logic object_culled = 1'b0;
  logic last_triangle = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic backface_out, tested, last_out;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  bit src_idle = 1'b0;
  bit sink_stall = 1'b0;
  coord_t cam_x = '0, cam_y = '0, cam_z = '0;

  always #4 clk = ~clk;

  triangle_backface_cull i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .p0_x, .p0_y, .p0_z, .p1_x, .p1_y, .p1_z, .p2_x, .p2_y, .p2_z,
    .poly_status, .object_culled, .last_triangle,
    .out_valid, .out_ready, .backface_out, .tested, .last_out
  );

  triangle_backface_cull_checker i_checker (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .p0_x, .p0_y, .p0_z, .p1_x, .p1_y, .p1_z, .p2_x, .p2_y, .p2_z,
    .poly_status, .object_culled, .last_triangle,
    .out_valid, .out_ready, .backface_out, .tested, .last_out,
    .fail_count, .outstanding
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int jitter();
    return int'($urandom_range(0, 128)) - 64;
  endfunction

  function automatic triangle_t make_tri(
    input int x0, input int y0, input int z0,
    input int x1, input int y1, input int z1,
    input int x2, input int y2, input int z2,
    input logic [3:0] status, input logic culled, input logic last
  );
    triangle_t t;
    t.x0 = coord_t'(x0); t.y0 = coord_t'(y0); t.z0 = coord_t'(z0);
    t.x1 = coord_t'(x1); t.y1 = coord_t'(y1); t.z1 = coord_t'(z1);
    t.x2 = coord_t'(x2); t.y2 = coord_t'(y2); t.z2 = coord_t'(z2);
    t.status = status;
    t.culled = culled;
    t.last   = last;
    return t;
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t t;
    int kind, dx, dy, dz;
    kind = $urandom_range(0, 99);
    t = make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, ST_ACTIVE, 1'b0, 1'b0);
    if (kind < 50) begin
      // full-range coordinates as drawn
    end else if (kind < 75) begin
      // small triangle close to the camera: sign decided at fine scale
      t = make_tri(cam_x + jitter(), cam_y + jitter(), cam_z + jitter(),
                   cam_x + jitter(), cam_y + jitter(), cam_z + jitter(),
                   cam_x + jitter(), cam_y + jitter(), cam_z + jitter(),
                   ST_ACTIVE, 1'b0, 1'b0);
    end else if (kind < 85) begin
      // collinear vertices, zero normal
      dx = jitter();
      dy = jitter();
      dz = jitter();
      t = make_tri(t.x0, t.y0, t.z0, t.x0 + dx, t.y0 + dy, t.z0 + dz,
                   t.x0 + 2 * dx, t.y0 + 2 * dy, t.z0 + 2 * dz,
                   ST_ACTIVE, 1'b0, 1'b0);
    end else if (kind < 92) begin
      // camera sits on the first vertex, view vector is zero
      t.x0 = cam_x;
      t.y0 = cam_y;
      t.z0 = cam_z;
    end else begin
      t = make_tri(jitter(), jitter(), jitter(), jitter(), jitter(), jitter(),
                   jitter(), jitter(), jitter(), ST_ACTIVE, 1'b0, 1'b0);
    end
    if ($urandom_range(0, 3) == 0) t.status = 4'($urandom);
    t.culled = ($urandom_range(0, 9) == 0);
    t.last   = ($urandom_range(0, 3) == 0);
    return t;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance, or after an idle gap when src_idle is set
  task automatic send_triangle(input triangle_t t);
    p0_x = t.x0; p0_y = t.y0; p0_z = t.z0;
    p1_x = t.x1; p1_y = t.y1; p1_z = t.z1;
    p2_x = t.x2; p2_y = t.y2; p2_z = t.z2;
    poly_status   = t.status;
    object_culled = t.culled;
    last_triangle = t.last;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (src_idle && $urandom_range(0, 99) < 30) begin
      in_valid = 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index, input coord_t data);
    cfg_index = index;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    case (index)
      REG_CAMERA_X: cam_x = data;
      REG_CAMERA_Y: cam_y = data;
      REG_CAMERA_Z: cam_z = data;
      default: ;
    endcase
  endtask

  task automatic drain_pipe();
    in_valid = 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  task automatic program_camera(input int x, input int y, input int z);
    drain_pipe();
    write_reg(REG_CAMERA_X, coord_t'(x));
    write_reg(REG_CAMERA_Y, coord_t'(y));
    write_reg(REG_CAMERA_Z, coord_t'(z));
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(input int count, input int pause_at);
    int i;
    for (i = 0; i < count; i++) begin
      if (i == pause_at) drain_pipe();
      send_triangle(random_triangle());
    end
  endtask

  // camera still at its reset value (origin)
  task automatic run_directed();
    // facing the camera, then the same triangle wound the other way
    send_triangle(make_tri(0, 0, -160, 16, 0, -160, 0, 16, -160, ST_ACTIVE, 0, 0));
    send_triangle(make_tri(0, 0, -160, 0, 16, -160, 16, 0, -160, ST_ACTIVE, 0, 1));
    // degenerate: repeated vertex and collinear vertices
    send_triangle(make_tri(5, 7, -9, 5, 7, -9, 40, -3, 11, ST_ACTIVE, 0, 0));
    send_triangle(make_tri(-20, 4, 8, -10, 8, 12, 0, 12, 16, ST_ACTIVE, 0, 0));
    // camera lies in the plane of the triangle
    send_triangle(make_tri(-48, 32, 0, 64, -16, 0, 8, 80, 0, ST_ACTIVE, 0, 0));
    // full-scale coordinates
    send_triangle(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                           -32768, 32767, -32768, ST_ACTIVE, 0, 0));
    send_triangle(make_tri(-32768, -32768, -32768, -32768, 32767, -32768,
                           32767, -32768, -32768, ST_ACTIVE, 0, 0));
    send_triangle(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                           32767, -32768, 32767, ST_ACTIVE, 0, 1));
    send_triangle(make_tri(32767, -32768, 32767, -32768, 32767, -32768,
                           32767, 32767, -32768, ST_ACTIVE, 0, 0));
    send_triangle(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                           -32768, -32768, 32767, ST_ACTIVE, 0, 0));
    // every reason to skip the test
    send_triangle(make_tri(0, 0, -160, 16, 0, -160, 0, 16, -160, ST_INACTIVE, 0, 0));
    send_triangle(make_tri(0, 0, -160, 16, 0, -160, 0, 16, -160, ST_CLIPPED, 0, 0));
    send_triangle(make_tri(0, 0, -160, 16, 0, -160, 0, 16, -160, ST_TWO_SIDE, 0, 1));
    send_triangle(make_tri(0, 0, -160, 16, 0, -160, 0, 16, -160, ST_BACK, 0, 0));
    send_triangle(make_tri(0, 0, -160, 16, 0, -160, 0, 16, -160, ST_BACK_ONLY, 0, 0));
    send_triangle(make_tri(0, 0, -160, 16, 0, -160, 0, 16, -160, 4'hf, 0, 1));
    send_triangle(make_tri(0, 0, -160, 16, 0, -160, 0, 16, -160, ST_ACTIVE, 1, 0));
    send_triangle(make_tri(0, 0, -160, 0, 16, -160, 16, 0, -160, ST_BACK, 1, 1));
    send_triangle(make_tri(0, 0, -160, 0, 16, -160, 16, 0, -160, ST_INACTIVE, 1, 0));
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("triangle_backface_cull_tb failed");
      $finish;
    end
  end

  // output back-pressure
  initial begin
    repeat (3) @(negedge clk);
    forever begin
      @(negedge clk);
      if (sink_stall && $urandom_range(0, 99) < 30) begin
        out_ready = 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();

    program_camera(32767, 32767, 32767);
    src_idle   = 1'b1;
    sink_stall = 1'b1;
    run_random(PHASE_ITEMS, PHASE_ITEMS / 2);

    program_camera(-32768, -32768, -32768);
    run_random(PHASE_ITEMS, -1);

    // write the unused index (ignored by the design), then all three camera registers
    drain_pipe();
    write_reg(REG_UNUSED, coord_t'($urandom));
    write_reg(REG_CAMERA_X, coord_t'($urandom));
    write_reg(REG_CAMERA_Y, coord_t'($urandom));
    write_reg(REG_CAMERA_Z, coord_t'($urandom));
    cfg_valid = 1'b0;
    src_idle  = 1'b0;
    run_random(PHASE_ITEMS, -1);

    program_camera(32767, -32768, 0);
    src_idle   = 1'b1;
    sink_stall = 1'b0;
    run_random(PHASE_ITEMS, -1);

    program_camera($urandom, $urandom, $urandom);
    sink_stall = 1'b1;
    run_random(PHASE_ITEMS, -1);

    in_valid = 1'b0;
    wait (outstanding == 0);
    repeat (4 * PIPE_LATENCY) @(posedge clk);
    if (fail_count == 0)
      $display("triangle_backface_cull_tb passed");
    else
      $display("triangle_backface_cull_tb failed");
    $finish;
  end

endmodule
